FILE: hw/rtl/positional_list_store_defines.svh
// Assertion macros shared by the positional list store RTL.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

`ifndef SYNTHESIS
// property holds on every rising clock edge out of reset
`define PLS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true out of reset
`define PLS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PLS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

FILE: hw/rtl/pls_pkg.sv
// Types and constants of the positional list store.
`default_nettype none

package pls_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_BACK  = 3'd3,
    OP_INS_AT    = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_REVERSE   = 3'd6,
    OP_DUMP      = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pls_ram.sv
// Entry memory: one write port, one read port, registered read data.
`default_nettype none

module pls_ram (
  input  logic                         clk_i,
  input  pls_pkg::ram_req_t            req_i,
  output logic [pls_pkg::DATA_W-1:0]   rdata_o
);
  import pls_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_store.sv
// Top level of the positional list store: sequencer around the entry memory.
//
//  port group     | dir | transfer
//  ---------------+-----+----------------------------------------------------
//  command        | in  | start_i high while busy_o low; operation, position, value
//  result         | out | result_valid_o high for one cycle; status, count, value, last
//
//  Faulted commands (bad position, empty, full) and short reverses answer in the
//  cycle after the transfer. An insert or delete moves one entry at a time,
//  reading it, then writing it, through the single memory read/write path.
//  Reverse swaps each pair by reading both ends, then writing both ends; dump
//  reads each entry, then outputs it. Reset clears the count and sequencer only;
//  the entry memory is not cleared. The receiver cannot stall results.
`default_nettype none
`include "positional_list_store_defines.svh"

module positional_list_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [pls_pkg::OP_W-1:0]        operation_i,
  input  logic [pls_pkg::POS_W-1:0]       position_i,
  input  logic signed [pls_pkg::DATA_W-1:0] value_i,
  output logic                            result_valid_o,
  output logic [pls_pkg::STATUS_W-1:0]    status_o,
  output logic [pls_pkg::COUNT_W-1:0]     count_o,
  output logic signed [pls_pkg::DATA_W-1:0] value_res_o,
  output logic                            last_o
);
  import pls_pkg::*;

  localparam int CMP_W = POS_W + 1;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_INS     = 11'b000_0000_0010,
    S_INS_WR  = 11'b000_0000_0100,
    S_DEL     = 11'b000_0000_1000,
    S_DEL_WR  = 11'b000_0001_0000,
    S_REV_RDA = 11'b000_0010_0000,
    S_REV_RDB = 11'b000_0100_0000,
    S_REV_WRA = 11'b000_1000_0000,
    S_REV_WRB = 11'b001_0000_0000,
    S_DMP_RD  = 11'b010_0000_0000,
    S_DMP_OUT = 11'b100_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [IDX_W-1:0]  hi_q, hi_d;
  logic [IDX_W-1:0]  stop_q, stop_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] tmp_q, tmp_d;

  logic              rvalid_q;
  status_e           status_q;
  logic [CNT_W-1:0]  rcount_q;
  logic [DATA_W-1:0] rvalue_q;
  logic              rlast_q;

  logic              emit;
  status_e           em_status;
  logic [DATA_W-1:0] em_value;
  logic              em_last;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              full;
  logic              empty;

  pls_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign pos_ext = CMP_W'(position_i);
  assign cnt_ext = CMP_W'(count_q);
  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    ptr_d         = ptr_q;
    hi_d          = hi_q;
    stop_d        = stop_q;
    val_d         = val_q;
    tmp_d         = tmp_q;
    emit          = 1'b0;
    em_status     = ST_OK;
    em_value      = '0;
    em_last       = 1'b1;
    ram_req.we    = 1'b0;
    ram_req.waddr = ptr_q;
    ram_req.wdata = ram_rdata;
    ram_req.raddr = ptr_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d = value_i;
          case (op_e'(operation_i))
            OP_INS_FRONT, OP_INS_BACK: begin
              if (full) begin
                emit      = 1'b1;
                em_status = ST_FULL;
              end else begin
                ptr_d   = IDX_W'(count_q);
                stop_d  = (op_e'(operation_i) == OP_INS_FRONT) ? '0 : IDX_W'(count_q);
                state_d = S_INS;
              end
            end
            OP_INS_AT: begin
              if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                emit      = 1'b1;
                em_status = ST_BADPOS;
              end else if (full) begin
                emit      = 1'b1;
                em_status = ST_FULL;
              end else begin
                ptr_d   = IDX_W'(count_q);
                stop_d  = IDX_W'(position_i - POS_W'(1));
                state_d = S_INS;
              end
            end
            OP_DEL_FRONT, OP_DEL_BACK: begin
              if (empty) begin
                emit      = 1'b1;
                em_status = ST_EMPTY;
              end else begin
                ptr_d   = (op_e'(operation_i) == OP_DEL_FRONT) ? '0 :
                          IDX_W'(count_q - CNT_W'(1));
                state_d = S_DEL;
              end
            end
            OP_DEL_AT: begin
              if (pos_ext == '0 || pos_ext > cnt_ext) begin
                emit      = 1'b1;
                em_status = ST_BADPOS;
              end else begin
                ptr_d   = IDX_W'(position_i - POS_W'(1));
                state_d = S_DEL;
              end
            end
            OP_REVERSE: begin
              if (count_q < CNT_W'(2)) begin
                emit = 1'b1;
              end else begin
                ptr_d   = '0;
                hi_d    = IDX_W'(count_q - CNT_W'(1));
                state_d = S_REV_RDA;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                emit      = 1'b1;
                em_status = ST_EMPTY;
              end else begin
                ptr_d   = '0;
                state_d = S_DMP_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // open a gap at stop_q, moving entries up one at a time from the tail
      S_INS: begin
        if (ptr_q == stop_q) begin
          ram_req.we    = 1'b1;
          ram_req.wdata = val_q;
          count_d       = count_q + CNT_W'(1);
          emit          = 1'b1;
          state_d       = S_IDLE;
        end else begin
          ram_req.raddr = ptr_q - IDX_W'(1);
          state_d       = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ram_req.we = 1'b1;
        ptr_d      = ptr_q - IDX_W'(1);
        state_d    = S_INS;
      end

      // close the hole at ptr_q, pulling later entries down
      S_DEL: begin
        if (CNT_W'(ptr_q) + CNT_W'(1) >= count_q) begin
          count_d = count_q - CNT_W'(1);
          emit    = 1'b1;
          state_d = S_IDLE;
        end else begin
          ram_req.raddr = ptr_q + IDX_W'(1);
          state_d       = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        ram_req.we = 1'b1;
        ptr_d      = ptr_q + IDX_W'(1);
        state_d    = S_DEL;
      end

      // swap ptr_q (low end) and hi_q (high end)
      S_REV_RDA: begin
        state_d = S_REV_RDB;
      end
      S_REV_RDB: begin
        ram_req.raddr = hi_q;
        tmp_d         = ram_rdata;
        state_d       = S_REV_WRA;
      end
      S_REV_WRA: begin
        ram_req.we = 1'b1;
        state_d    = S_REV_WRB;
      end
      S_REV_WRB: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = hi_q;
        ram_req.wdata = tmp_q;
        if (ptr_q + IDX_W'(1) < hi_q - IDX_W'(1)) begin
          ptr_d   = ptr_q + IDX_W'(1);
          hi_d    = hi_q - IDX_W'(1);
          state_d = S_REV_RDA;
        end else begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_DMP_RD: begin
        state_d = S_DMP_OUT;
      end
      S_DMP_OUT: begin
        emit     = 1'b1;
        em_value = ram_rdata;
        em_last  = (CNT_W'(ptr_q) == count_q - CNT_W'(1));
        ptr_d    = ptr_q + IDX_W'(1);
        state_d  = em_last ? S_IDLE : S_DMP_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rvalid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    hi_q   <= hi_d;
    stop_q <= stop_d;
    val_q  <= val_d;
    tmp_q  <= tmp_d;
    if (emit) begin
      status_q <= em_status;
      rcount_q <= count_d;
      rvalue_q <= em_value;
      rlast_q  <= em_last;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = rvalid_q;
  assign status_o       = status_q;
  assign count_o        = COUNT_W'(rcount_q);
  assign value_res_o    = rvalue_q;
  assign last_o         = rlast_q;

  `PLS_ASSERT_NEVER(a_count_max, clk_i, rst_ni, count_q > CNT_W'(DEPTH), "count above depth")
  `PLS_ASSERT(a_last_idle, clk_i, rst_ni, result_valid_o && last_o |-> !busy_o, "busy after last result")
  `PLS_ASSERT(a_start_acts, clk_i, rst_ni, start_i && !busy_o |=> busy_o || result_valid_o, "command dropped")
  `PLS_ASSERT(a_count_with_result, clk_i, rst_ni, !$stable(count_q) |-> result_valid_o, "count moved silently")

endmodule

`default_nettype wire

FILE: test/tb_positional_list_store.sv
// Self-checking testbench for the positional list store: directed and random list commands.
`timescale 1ns / 1ps

module tb_positional_list_store;
  import pls_pkg::*;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } list_result_t;

  // Tracks the list contents and the results each command should produce.
  class list_scoreboard;
    logic signed [DATA_W-1:0] entries [DEPTH];
    int                       entry_count;
    list_result_t             pending[$];
    int unsigned              fails;

    function new();
      entry_count = 0;
      fails = 0;
    endfunction

    function void queue_result(status_e st, logic signed [DATA_W-1:0] v, logic l);
      list_result_t r;
      r.status = st;
      r.count  = entry_count[COUNT_W-1:0];
      r.value  = v;
      r.last   = l;
      pending.push_back(r);
    endfunction

    function status_e insert_at(int idx, logic signed [DATA_W-1:0] v);
      if (entry_count >= DEPTH) return ST_FULL;
      for (int i = entry_count; i > idx; i--) entries[i] = entries[i-1];
      entries[idx] = v;
      entry_count++;
      return ST_OK;
    endfunction

    function void remove_at(int idx);
      for (int i = idx; i + 1 < entry_count; i++) entries[i] = entries[i+1];
      entry_count--;
    endfunction

    // Called once per accepted command transfer.
    function void take_command(op_e op, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] v);
      status_e                  st;
      int                       p;
      int                       lo;
      int                       hi;
      logic signed [DATA_W-1:0] tmp;
      st = ST_OK;
      p  = int'(pos);
      case (op)
        OP_INS_FRONT: st = insert_at(0, v);
        OP_INS_BACK:  st = insert_at(entry_count, v);
        OP_DEL_FRONT: begin
          if (entry_count == 0) st = ST_EMPTY;
          else remove_at(0);
        end
        OP_DEL_BACK: begin
          if (entry_count == 0) st = ST_EMPTY;
          else remove_at(entry_count - 1);
        end
        OP_INS_AT: begin
          // position check wins over the full check
          if (p < 1 || p > entry_count + 1) st = ST_BADPOS;
          else st = insert_at(p - 1, v);
        end
        OP_DEL_AT: begin
          if (p < 1 || p > entry_count) st = ST_BADPOS;
          else remove_at(p - 1);
        end
        OP_REVERSE: begin
          lo = 0;
          hi = entry_count - 1;
          while (lo < hi) begin
            tmp = entries[lo];
            entries[lo] = entries[hi];
            entries[hi] = tmp;
            lo++;
            hi--;
          end
        end
        default: begin
          if (entry_count == 0) queue_result(ST_EMPTY, '0, 1'b1);
          for (int i = 0; i < entry_count; i++)
            queue_result(ST_OK, entries[i], (i + 1 == entry_count));
          return;
        end
      endcase
      queue_result(st, '0, 1'b1);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt,
                               logic signed [DATA_W-1:0] v, logic l);
      list_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: status %0d count %0d value %0d last %0b", st, cnt, v, l);
        fails++;
        return;
      end
      want = pending.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        fails++;
      end
      if (cnt !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, cnt);
        fails++;
      end
      if (v !== want.value) begin
        $error("value_res: expected %0d, got %0d", want.value, v);
        fails++;
      end
      if (l !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, l);
        fails++;
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [OP_W-1:0]          operation_i;
  logic [POS_W-1:0]         position_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     result_valid_o;
  logic [STATUS_W-1:0]      status_o;
  logic [COUNT_W-1:0]       count_o;
  logic signed [DATA_W-1:0] value_res_o;
  logic                     last_o;

  list_scoreboard sb;
  bit             growing;

  positional_list_store DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .count_o        (count_o),
    .value_res_o    (value_res_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(status_o, count_o, value_res_o, last_o);
  end

  // Holds start high until the transfer happens; start is left high on return.
  task automatic send_command(op_e op, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] v);
    start_i     <= 1'b1;
    operation_i <= op;
    position_i  <= pos;
    value_i     <= v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.take_command(op, pos, v);
  endtask

  task automatic pause_sender(int cycles);
    start_i     <= 1'b0;
    operation_i <= OP_W'($urandom);
    position_i  <= POS_W'($urandom);
    value_i     <= $urandom;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_command();
    int                       c;
    int                       r;
    int                       ins_w;
    int                       del_w;
    op_e                      op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] v;
    c = sb.entry_count;
    if (c == 0) growing = 1'b1;
    else if (c == DEPTH && $urandom_range(3) == 0) growing = 1'b0;
    ins_w = growing ? 60 : 21;
    del_w = growing ? 18 : 57;
    r = $urandom_range(99);
    if (r < ins_w) begin
      case ($urandom_range(2))
        0:       op = OP_INS_FRONT;
        1:       op = OP_INS_BACK;
        default: op = OP_INS_AT;
      endcase
    end else if (r < ins_w + del_w) begin
      case ($urandom_range(2))
        0:       op = OP_DEL_FRONT;
        1:       op = OP_DEL_BACK;
        default: op = OP_DEL_AT;
      endcase
    end else if (r < ins_w + del_w + 10) begin
      op = OP_REVERSE;
    end else begin
      op = OP_DUMP;
    end
    r = $urandom_range(99);
    if (r < 70) begin
      if (op == OP_INS_AT) pos = POS_W'($urandom_range(c + 1, 1));
      else pos = (c == 0) ? POS_W'(1) : POS_W'($urandom_range(c, 1));
    end else if (r < 78) begin
      pos = '0;
    end else if (r < 88) begin
      pos = POS_W'(c + 1 + int'($urandom_range(1)));
    end else begin
      pos = POS_W'($urandom_range(255));
    end
    case ($urandom_range(19))
      0:       v = 32'sh8000_0000;
      1:       v = 32'sh7fff_ffff;
      2:       v = '0;
      3:       v = '1;
      default: v = $urandom;
    endcase
    send_command(op, pos, v);
  endtask

  initial begin
    int idle_pct [3];
    idle_pct = '{29, 84, 0};
    sb          = new();
    growing     = 1'b1;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    operation_i = '0;
    position_i  = '0;
    value_i     = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty-list corner cases
    send_command(OP_DUMP, 8'd0, 0);
    send_command(OP_DEL_FRONT, 8'd0, 0);
    send_command(OP_DEL_BACK, 8'd0, 0);
    send_command(OP_DEL_AT, 8'd1, 0);
    send_command(OP_DEL_AT, 8'd0, 0);
    send_command(OP_REVERSE, 8'd0, 0);
    send_command(OP_INS_AT, 8'd0, 32'sd5);
    send_command(OP_INS_AT, 8'd2, 32'sd5);
    send_command(OP_INS_AT, 8'd255, 32'sd5);
    // build a short list, reverse and dump it
    send_command(OP_INS_FRONT, 8'd255, 32'sh8000_0000);
    send_command(OP_REVERSE, 8'd0, 0);
    send_command(OP_INS_BACK, 8'd0, 32'sh7fff_ffff);
    send_command(OP_INS_AT, 8'd2, -32'sd1);
    send_command(OP_INS_AT, 8'd4, 32'sd0);
    send_command(OP_INS_AT, 8'd1, 32'sh5555_5555);
    send_command(OP_DUMP, 8'd0, 0);
    send_command(OP_REVERSE, 8'd0, 0);
    send_command(OP_DUMP, 8'd0, 0);
    send_command(OP_DEL_AT, 8'd255, 0);
    send_command(OP_DEL_AT, 8'd6, 0);
    send_command(OP_DEL_AT, 8'd5, 0);
    send_command(OP_DEL_AT, 8'd2, 0);
    send_command(OP_DEL_FRONT, 8'd0, 0);
    send_command(OP_DEL_BACK, 8'd0, 0);
    send_command(OP_DUMP, 8'd0, 0);
    // hold off until every transfer has been answered
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < 42; n++) begin
        // idle cycle by cycle at the phase's rate
        while ($urandom_range(99) < idle_pct[ph]) pause_sender(1);
        random_command();
      end
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
